@@ sv/mtg_pkg.sv @@
package mtg_pkg;

	localparam int unsigned STATE_WORDS   = 624;
	localparam int unsigned MIDDLE_OFFSET = 397;
	localparam int unsigned IDX_W         = 10;

	localparam logic [31:0] TWIST_MATRIX = 32'h9908_b0df;
	localparam logic [31:0] HIGH_BIT     = 32'h8000_0000;
	localparam logic [31:0] LOW_BITS     = 32'h7fff_ffff;
	localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
	localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;
	localparam logic [31:0] LINEAR_MULT  = 32'd1812433253;
	localparam logic [31:0] MIX1_MULT    = 32'd1664525;
	localparam logic [31:0] MIX2_MULT    = 32'd1566083941;
	localparam logic [31:0] DEFAULT_SEED = 32'd19650218;

	localparam logic [1:0] REQ_SEED   = 2'd0;
	localparam logic [1:0] REQ_GEN    = 2'd1;
	localparam logic [1:0] REQ_KEY    = 2'd2;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	typedef enum logic [4:0] {
		DP_NOP,
		DP_SEED_LOAD,
		DP_LIN_MUL,
		DP_LIN_WR,
		DP_MIX1_INIT,
		DP_MIX2_INIT,
		DP_MIX_RD,
		DP_MIX_WR,
		DP_SET_TOP,
		DP_KEY_WR,
		DP_TW_INIT,
		DP_TW_CUR,
		DP_TW_RN,
		DP_TW_RF,
		DP_TW_WR,
		DP_GEN_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   use_default;
		logic   pass2;
	} dp_cmd_t;

	typedef struct packed {
		logic lin_last;
		logic mix_last;
		logic tw_last;
		logic need_twist;
		logic out_free;
	} dp_stat_t;

	function automatic logic [31:0] temper(input logic [31:0] w);
		logic [31:0] y;
		y = w ^ (w >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

	function automatic logic [31:0] fold30(input logic [31:0] w);
		return w ^ (w >> 30);
	endfunction

endpackage

@@ sv/mtg_dp.sv @@
module mtg_dp #(
	parameter int unsigned KEY_DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mtg_pkg::dp_cmd_t  cmd,
	input  logic              in_accept,
	input  logic [31:0]       in_value,
	output mtg_pkg::dp_stat_t stat,
	output logic              out_valid,
	output logic [31:0]       out_word,
	input  logic              out_ready
);

	localparam int unsigned KCW = $clog2(KEY_DEPTH + 1);
	localparam int unsigned KAW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
	localparam int unsigned IW  = mtg_pkg::IDX_W;
	localparam logic [IW-1:0] LAST_IDX = IW'(mtg_pkg::STATE_WORDS - 1);

	logic [31:0]    mem_q [mtg_pkg::STATE_WORDS];
	logic [31:0]    key_mem_q [KEY_DEPTH];
	logic [31:0]    rd_q, key_rd_q, prev_q, prod_q, nxt_q, cur_q, val_q, out_q;
	logic [IW-1:0]  idx_q, k_q, rdi_q, raddr, far_addr, nxt_addr;
	logic [KCW-1:0] j_q, kcnt_q;
	logic           out_valid_q;

	logic           wen;
	logic [IW-1:0]  waddr;
	logic [31:0]    wdata, lin_word, mix_x, mix_new, tw_y, tw_word, seed_word, mul_b;
	logic [KCW:0]   j_inc;

	assign seed_word = cmd.use_default ? mtg_pkg::DEFAULT_SEED : val_q;
	assign lin_word  = prod_q + 32'(idx_q);
	assign mix_x     = rd_q ^ prod_q;
	assign mix_new   = cmd.pass2 ? (mix_x - 32'(idx_q)) : (mix_x + key_rd_q + 32'(j_q));
	assign tw_y      = (cur_q & mtg_pkg::HIGH_BIT) | (nxt_q & mtg_pkg::LOW_BITS);
	assign tw_word   = rd_q ^ (tw_y >> 1) ^ (tw_y[0] ? mtg_pkg::TWIST_MATRIX : 32'd0);
	assign nxt_addr  = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
	assign far_addr  = (idx_q < IW'(mtg_pkg::STATE_WORDS - mtg_pkg::MIDDLE_OFFSET))
		? idx_q + IW'(mtg_pkg::MIDDLE_OFFSET)
		: idx_q - IW'(mtg_pkg::STATE_WORDS - mtg_pkg::MIDDLE_OFFSET);
	assign j_inc     = {1'b0, j_q} + 1'b1;
	assign mul_b     = (cmd.op == mtg_pkg::DP_LIN_MUL) ? mtg_pkg::LINEAR_MULT
		: (cmd.pass2 ? mtg_pkg::MIX2_MULT : mtg_pkg::MIX1_MULT);

	always_comb begin
		wen   = 1'b0;
		waddr = idx_q;
		wdata = lin_word;
		raddr = rdi_q;
		unique case (cmd.op)
			mtg_pkg::DP_SEED_LOAD: begin
				wen   = 1'b1;
				waddr = '0;
				wdata = seed_word;
			end
			mtg_pkg::DP_LIN_WR: wen = 1'b1;
			mtg_pkg::DP_MIX_RD: raddr = idx_q;
			mtg_pkg::DP_MIX_WR: begin
				wen   = 1'b1;
				wdata = mix_new;
			end
			mtg_pkg::DP_SET_TOP: begin
				wen   = 1'b1;
				waddr = '0;
				wdata = mtg_pkg::HIGH_BIT;
			end
			mtg_pkg::DP_TW_INIT: raddr = '0;
			mtg_pkg::DP_TW_RN: raddr = nxt_addr;
			mtg_pkg::DP_TW_RF: raddr = far_addr;
			mtg_pkg::DP_TW_WR: begin
				wen   = 1'b1;
				wdata = tw_word;
			end
			default: ;
		endcase
	end

	// state and key memories
	always_ff @(posedge clk) begin
		if (wen) mem_q[waddr] <= wdata;
		rd_q <= mem_q[raddr];
		if (cmd.op == mtg_pkg::DP_KEY_WR && kcnt_q < KCW'(KEY_DEPTH))
			key_mem_q[kcnt_q[KAW-1:0]] <= val_q;
		key_rd_q <= key_mem_q[j_q[KAW-1:0]];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_accept) val_q <= in_value;
		unique case (cmd.op)
			mtg_pkg::DP_SEED_LOAD: prev_q <= seed_word;
			mtg_pkg::DP_LIN_MUL,
			mtg_pkg::DP_MIX_RD: prod_q <= mtg_pkg::fold30(prev_q) * mul_b;
			mtg_pkg::DP_LIN_WR: prev_q <= lin_word;
			mtg_pkg::DP_MIX1_INIT: prev_q <= mtg_pkg::DEFAULT_SEED;
			mtg_pkg::DP_MIX_WR: prev_q <= mix_new;
			mtg_pkg::DP_TW_CUR: cur_q <= rd_q;
			mtg_pkg::DP_TW_RF: nxt_q <= rd_q;
			mtg_pkg::DP_TW_WR: cur_q <= nxt_q;
			mtg_pkg::DP_GEN_OUT: out_q <= mtg_pkg::temper(rd_q);
			default: ;
		endcase
	end

	// counters and output flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			k_q         <= '0;
			j_q         <= '0;
			kcnt_q      <= '0;
			rdi_q       <= IW'(mtg_pkg::STATE_WORDS);
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == mtg_pkg::DP_GEN_OUT) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (cmd.op)
				mtg_pkg::DP_SEED_LOAD: begin
					idx_q <= IW'(1);
					rdi_q <= IW'(mtg_pkg::STATE_WORDS);
				end
				mtg_pkg::DP_LIN_WR: idx_q <= idx_q + 1'b1;
				mtg_pkg::DP_MIX1_INIT: begin
					idx_q <= IW'(1);
					j_q   <= '0;
					k_q   <= IW'(mtg_pkg::STATE_WORDS);
				end
				mtg_pkg::DP_MIX2_INIT: k_q <= LAST_IDX;
				mtg_pkg::DP_MIX_WR: begin
					idx_q <= (idx_q == LAST_IDX) ? IW'(1) : idx_q + 1'b1;
					j_q   <= (j_inc >= {1'b0, kcnt_q}) ? '0 : j_inc[KCW-1:0];
					k_q   <= k_q - 1'b1;
				end
				mtg_pkg::DP_SET_TOP: begin
					kcnt_q <= '0;
					rdi_q  <= IW'(mtg_pkg::STATE_WORDS);
				end
				mtg_pkg::DP_KEY_WR:
					if (kcnt_q < KCW'(KEY_DEPTH)) kcnt_q <= kcnt_q + 1'b1;
				mtg_pkg::DP_TW_INIT: idx_q <= '0;
				mtg_pkg::DP_TW_WR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == LAST_IDX) rdi_q <= '0;
				end
				mtg_pkg::DP_GEN_OUT: rdi_q <= rdi_q + 1'b1;
				default: ;
			endcase
		end
	end

	assign stat.lin_last   = (idx_q == LAST_IDX);
	assign stat.mix_last   = (k_q == IW'(1));
	assign stat.tw_last    = (idx_q == LAST_IDX);
	assign stat.need_twist = (rdi_q == IW'(mtg_pkg::STATE_WORDS));
	assign stat.out_free   = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign out_word        = out_q;

endmodule

@@ sv/mtg_ctrl.sv @@
module mtg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        in_req,
	input  logic              in_last,
	output logic              in_ready,
	input  mtg_pkg::dp_stat_t stat,
	output mtg_pkg::dp_cmd_t  cmd
);

	typedef enum logic [4:0] {
		S_IDLE, S_SEED, S_LMUL, S_LWR, S_M1I, S_M2I, S_MRD, S_MWR, S_TOP,
		S_KEY, S_TWI, S_TWC, S_TRN, S_TRF, S_TWR, S_GRD, S_GOUT
	} state_t;

	state_t state_q;
	logic   use_def_q, mix_q, pass2_q, last_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd.use_default = use_def_q;
		cmd.pass2       = pass2_q;
		unique case (state_q)
			S_SEED: cmd.op = mtg_pkg::DP_SEED_LOAD;
			S_LMUL: cmd.op = mtg_pkg::DP_LIN_MUL;
			S_LWR:  cmd.op = mtg_pkg::DP_LIN_WR;
			S_M1I:  cmd.op = mtg_pkg::DP_MIX1_INIT;
			S_M2I:  cmd.op = mtg_pkg::DP_MIX2_INIT;
			S_MRD:  cmd.op = mtg_pkg::DP_MIX_RD;
			S_MWR:  cmd.op = mtg_pkg::DP_MIX_WR;
			S_TOP:  cmd.op = mtg_pkg::DP_SET_TOP;
			S_KEY:  cmd.op = mtg_pkg::DP_KEY_WR;
			S_TWI:  cmd.op = mtg_pkg::DP_TW_INIT;
			S_TWC:  cmd.op = mtg_pkg::DP_TW_CUR;
			S_TRN:  cmd.op = mtg_pkg::DP_TW_RN;
			S_TRF:  cmd.op = mtg_pkg::DP_TW_RF;
			S_TWR:  cmd.op = mtg_pkg::DP_TW_WR;
			S_GOUT: cmd.op = stat.out_free ? mtg_pkg::DP_GEN_OUT : mtg_pkg::DP_NOP;
			default: cmd.op = mtg_pkg::DP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_SEED;
			use_def_q <= 1'b1;
			mix_q     <= 1'b0;
			pass2_q   <= 1'b0;
			last_q    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					unique case (in_req)
						mtg_pkg::REQ_SEED: begin
							state_q   <= S_SEED;
							use_def_q <= 1'b0;
							mix_q     <= 1'b0;
						end
						mtg_pkg::REQ_GEN: state_q <= stat.need_twist ? S_TWI : S_GRD;
						mtg_pkg::REQ_KEY: begin
							state_q <= S_KEY;
							last_q  <= in_last;
						end
						default: ;
					endcase
				end
				S_SEED: state_q <= S_LMUL;
				S_LMUL: state_q <= S_LWR;
				S_LWR: if (stat.lin_last) state_q <= mix_q ? S_M1I : S_IDLE;
					else state_q <= S_LMUL;
				S_M1I: begin
					pass2_q <= 1'b0;
					state_q <= S_MRD;
				end
				S_M2I: begin
					pass2_q <= 1'b1;
					state_q <= S_MRD;
				end
				S_MRD: state_q <= S_MWR;
				S_MWR: if (stat.mix_last) state_q <= pass2_q ? S_TOP : S_M2I;
					else state_q <= S_MRD;
				S_TOP: state_q <= S_IDLE;
				S_KEY: if (last_q) begin
					state_q   <= S_SEED;
					use_def_q <= 1'b1;
					mix_q     <= 1'b1;
				end else state_q <= S_IDLE;
				S_TWI: state_q <= S_TWC;
				S_TWC: state_q <= S_TRN;
				S_TRN: state_q <= S_TRF;
				S_TRF: state_q <= S_TWR;
				S_TWR: state_q <= stat.tw_last ? S_GRD : S_TRN;
				S_GRD: state_q <= S_GOUT;
				S_GOUT: if (stat.out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ sv/mersenne_twister_generator.sv @@
// generate beat: read and output steps when words remain, plus a full-state twist first
//   when used up, each word read next, read far, then written in the one-read one-write state ram
// seed beat: one multiply and one write per word
// last key beat: linear seed, then both mixing passes
// reset: a default seed pass (19650218) runs before s_tready rises
// results leave through an output register; a waiting beat stalls only the next generate
module mersenne_twister_generator #(
	parameter int unsigned KEY_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // seed_value
	input  logic [1:0]  s_tuser,  // req_type
	input  logic        s_tlast,  // key_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // random_word
);

	mtg_pkg::dp_cmd_t  cmd;
	mtg_pkg::dp_stat_t stat;

	// sequencer: decodes requests and steps the datapath through each pass
	mtg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_req   (s_tuser),
		.in_last  (s_tlast),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// state ram, key store, shared multiplier, twist and temper logic
	mtg_dp #(
		.KEY_DEPTH (KEY_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_accept (s_tvalid && s_tready),
		.in_value  (s_tdata),
		.stat      (stat),
		.out_valid (m_tvalid),
		.out_word  (m_tdata),
		.out_ready (m_tready)
	);

	// an idle sequencer never drives the datapath
	a_idle_nop: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> cmd.op == mtg_pkg::DP_NOP)
		else $error("datapath command issued while idle");

	// loading the output register always presents a beat
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == mtg_pkg::DP_GEN_OUT |=> m_tvalid)
		else $error("generated word not presented");

	// the last twist write leaves fresh words to read
	a_twist_done: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == mtg_pkg::DP_TW_WR && stat.tw_last) |=> !stat.need_twist)
		else $error("twist finished but state still marked used up");

endmodule

@@ verif/mersenne_twister_generator_tb.sv @@
`timescale 1ns / 1ps

module mersenne_twister_generator_tb;

	localparam int KEY_DEPTH   = 64;
	localparam int CYCLE_LIMIT = 3_000_000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // seed_value
	logic [1:0]  s_tuser;   // req_type
	logic        s_tlast;   // key_last
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // random_word

	// predictor state
	logic [31:0] mt_words [mtg_pkg::STATE_WORDS];
	int unsigned mt_pos;
	logic [31:0] key_words [KEY_DEPTH];
	int unsigned key_fill;

	logic [31:0] words_due [$];
	int          mismatches;
	int          cycle_count;
	bit          no_idle;

	mersenne_twister_generator #(.KEY_DEPTH(KEY_DEPTH)) DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// linear seeding recurrence over the whole state
	function automatic void mt_seed(input logic [31:0] s);
		logic [31:0] p;
		mt_words[0] = s;
		for (int i = 1; i < mtg_pkg::STATE_WORDS; i++) begin
			p = mt_words[i - 1];
			mt_words[i] = mtg_pkg::LINEAR_MULT * (p ^ (p >> 30)) + 32'(i);
		end
		mt_pos = mtg_pkg::STATE_WORDS;
	endfunction

	// key array seeding: default seed, then both mixing passes
	function automatic void mt_seed_key(input int unsigned len);
		int unsigned i, j, k;
		logic [31:0] p, mx;
		mt_seed(mtg_pkg::DEFAULT_SEED);
		i = 1;
		j = 0;
		k = (mtg_pkg::STATE_WORDS > len) ? mtg_pkg::STATE_WORDS : len;
		for (; k > 0; k--) begin
			p = mt_words[i - 1];
			mx = mt_words[i] ^ ((p ^ (p >> 30)) * mtg_pkg::MIX1_MULT);
			mt_words[i] = mx + key_words[j] + 32'(j);
			i++;
			j++;
			if (i >= mtg_pkg::STATE_WORDS) begin
				mt_words[0] = mt_words[mtg_pkg::STATE_WORDS - 1];
				i = 1;
			end
			if (j >= len) j = 0;
		end
		for (k = mtg_pkg::STATE_WORDS - 1; k > 0; k--) begin
			p = mt_words[i - 1];
			mx = mt_words[i] ^ ((p ^ (p >> 30)) * mtg_pkg::MIX2_MULT);
			mt_words[i] = mx - 32'(i);
			i++;
			if (i >= mtg_pkg::STATE_WORDS) begin
				mt_words[0] = mt_words[mtg_pkg::STATE_WORDS - 1];
				i = 1;
			end
		end
		mt_words[0] = mtg_pkg::HIGH_BIT;
		mt_pos = mtg_pkg::STATE_WORDS;
	endfunction

	function automatic void mt_twist();
		logic [31:0] y;
		for (int n = 0; n < mtg_pkg::STATE_WORDS; n++) begin
			y = (mt_words[n] & mtg_pkg::HIGH_BIT)
				| (mt_words[(n + 1) % mtg_pkg::STATE_WORDS] & mtg_pkg::LOW_BITS);
			mt_words[n] = mt_words[(n + mtg_pkg::MIDDLE_OFFSET) % mtg_pkg::STATE_WORDS]
				^ (y >> 1) ^ (y[0] ? mtg_pkg::TWIST_MATRIX : 32'h0);
		end
		mt_pos = 0;
	endfunction

	function automatic logic [31:0] mt_temper(input logic [31:0] w);
		logic [31:0] y;
		y = w ^ (w >> 11);
		y = y ^ ((y << 7) & mtg_pkg::TEMPER_B);
		y = y ^ ((y << 15) & mtg_pkg::TEMPER_C);
		return y ^ (y >> 18);
	endfunction

	// advance the predictor by one accepted request beat
	function automatic void mt_predict(input logic [1:0] req, input logic [31:0] val,
			input logic last);
		case (req)
			mtg_pkg::REQ_SEED: mt_seed(val);
			mtg_pkg::REQ_GEN: begin
				if (mt_pos >= mtg_pkg::STATE_WORDS) mt_twist();
				words_due.push_back(mt_temper(mt_words[mt_pos]));
				mt_pos++;
			end
			mtg_pkg::REQ_KEY: begin
				if (key_fill < KEY_DEPTH) begin
					key_words[key_fill] = val;
					key_fill++;
				end
				if (last) begin
					mt_seed_key(key_fill);
					key_fill = 0;
				end
			end
			default: ;
		endcase
	endfunction

	// send one request beat, with random idle before it
	task automatic send_req(input logic [1:0] req, input logic [31:0] val, input logic last);
		while (!no_idle && $urandom_range(99) < 17) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= val;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		mt_predict(req, val, last);
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(3))
			0: return 32'h0;
			1: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// result checker and random back-pressure
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (words_due.size() == 0) begin
				$error("random_word: unexpected beat, actual %h", m_tdata);
				mismatches++;
			end else begin
				if (m_tdata !== words_due[0]) begin
					$error("random_word: expected %h actual %h", words_due[0], m_tdata);
					mismatches++;
				end
				void'(words_due.pop_front());
			end
		end
	end

	always @(negedge clk)
		m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 17);

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// generate words straight after reset: default seed state
	task automatic test_reset_state();
		for (int n = 0; n < 8; n++) send_req(mtg_pkg::REQ_GEN, $urandom, n[0]);
	endtask

	// seed extremes, unused request type, key_last on other types, short key sequences
	task automatic test_directed();
		send_req(mtg_pkg::REQ_SEED, 32'h0, 1'b1);
		send_req(mtg_pkg::REQ_GEN, 32'hffff_ffff, 1'b1);
		send_req(mtg_pkg::REQ_UNUSED, 32'hffff_ffff, 1'b1);
		send_req(mtg_pkg::REQ_GEN, 32'h0, 1'b0);
		send_req(mtg_pkg::REQ_SEED, 32'hffff_ffff, 1'b0);
		send_req(mtg_pkg::REQ_GEN, 32'h0, 1'b0);
		send_req(mtg_pkg::REQ_KEY, 32'h0000_0123, 1'b0);
		send_req(mtg_pkg::REQ_KEY, 32'h0000_0234, 1'b0);
		send_req(mtg_pkg::REQ_KEY, 32'h0000_0345, 1'b0);
		send_req(mtg_pkg::REQ_KEY, 32'h0000_0456, 1'b1);
		send_req(mtg_pkg::REQ_GEN, 32'h0, 1'b0);
		send_req(mtg_pkg::REQ_GEN, 32'h0, 1'b0);
		send_req(mtg_pkg::REQ_KEY, 32'hffff_ffff, 1'b1);
		send_req(mtg_pkg::REQ_GEN, 32'h0, 1'b0);
	endtask

	// overfill the key store: extra words dropped, last still seeds
	task automatic test_key_overflow();
		for (int n = 0; n < KEY_DEPTH + 3; n++)
			send_req(mtg_pkg::REQ_KEY, $urandom, n == KEY_DEPTH + 2);
		send_req(mtg_pkg::REQ_GEN, 32'h0, 1'b0);
		for (int n = 0; n < KEY_DEPTH; n++)
			send_req(mtg_pkg::REQ_KEY, $urandom, n == KEY_DEPTH - 1);
		send_req(mtg_pkg::REQ_GEN, 32'h0, 1'b0);
	endtask

	// long generate run crossing at least one twist, no idling
	task automatic test_long_run();
		no_idle = 1'b1;
		for (int n = 0; n < 700; n++)
			send_req(mtg_pkg::REQ_GEN, $urandom, $urandom_range(1));
		no_idle = 1'b0;
	endtask

	// random mix, mostly generates, with short key sequences and seeds
	task automatic test_random();
		int pick;
		for (int n = 0; n < 350; n++) begin
			pick = $urandom_range(99);
			if (pick < 80) send_req(mtg_pkg::REQ_GEN, $urandom, $urandom_range(1));
			else if (pick < 85) send_req(mtg_pkg::REQ_SEED, rand_word(), $urandom_range(1));
			else if (pick < 88) send_req(mtg_pkg::REQ_UNUSED, $urandom, $urandom_range(1));
			else if (pick < 94) send_req(mtg_pkg::REQ_KEY, rand_word(), 1'b0);
			else begin
				for (int k = $urandom_range(5); k > 0; k--)
					send_req(mtg_pkg::REQ_KEY, rand_word(), 1'b0);
				send_req(mtg_pkg::REQ_KEY, rand_word(), 1'b1);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		mismatches = 0;
		cycle_count = 0;
		no_idle = 1'b0;
		key_fill = 0;
		for (int n = 0; n < KEY_DEPTH; n++) key_words[n] = '0;
		mt_seed(mtg_pkg::DEFAULT_SEED);
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_directed();
		test_key_overflow();
		test_long_run();
		test_random();
		s_tvalid <= 1'b0;

		while (words_due.size() != 0) @(posedge clk);
		repeat (4000) @(posedge clk);
		if (mismatches == 0 && words_due.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
